/* rtl/s5p_pkg.sv */
// Shared types, codes and constants of the SOCKS5 request parser.
package s5p_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned IPV4_W   = 32;
    localparam int unsigned PORT_W   = 16;
    localparam int unsigned Q_DEPTH  = 4;
    localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W  = Q_PTR_W + 1;
    localparam int unsigned IDX_W    = 4;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_REPLY  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DOMAIN = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DONE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SILENT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RELAY  = 3'd4;

    // Protocol bytes.
    localparam logic [BYTE_W-1:0] SOCKS_VER     = 8'h05;
    localparam logic [BYTE_W-1:0] METHOD_NOAUTH = 8'h00;
    localparam logic [BYTE_W-1:0] METHOD_REJECT = 8'hFF;
    localparam logic [BYTE_W-1:0] CMD_CONNECT   = 8'h01;
    localparam logic [BYTE_W-1:0] RSV_BYTE      = 8'h00;
    localparam logic [BYTE_W-1:0] ATYP_IPV4     = 8'h01;
    localparam logic [BYTE_W-1:0] ATYP_DOMAIN   = 8'h03;
    localparam logic [BYTE_W-1:0] REP_GENERAL   = 8'h01;
    localparam logic [BYTE_W-1:0] REP_BAD_CMD   = 8'h07;
    localparam logic [BYTE_W-1:0] REP_BAD_ATYP  = 8'h08;
    localparam logic [BYTE_W-1:0] ZERO_BYTE     = 8'h00;

    localparam logic [BYTE_W-1:0] IPV4_LEN = 8'd4;
    localparam logic [BYTE_W-1:0] PORT_LEN = 8'd2;

    // Header error codes held between request header bytes.
    typedef enum logic [1:0] {
        HE_NONE    = 2'd0,
        HE_BAD_HDR = 2'd1,
        HE_BAD_CMD = 2'd2
    } t_hdr_err;

    // Parser phase, one-hot.
    typedef enum logic [12:0] {
        PH_GREET_VER = 13'b0000000000001,
        PH_GREET_N   = 13'b0000000000010,
        PH_METHODS   = 13'b0000000000100,
        PH_REQ_VER   = 13'b0000000001000,
        PH_REQ_CMD   = 13'b0000000010000,
        PH_REQ_RSV   = 13'b0000000100000,
        PH_REQ_ATYP  = 13'b0000001000000,
        PH_IPV4      = 13'b0000010000000,
        PH_DOMLEN    = 13'b0000100000000,
        PH_DOMAIN    = 13'b0001000000000,
        PH_PORT      = 13'b0010000000000,
        PH_RELAY     = 13'b0100000000000,
        PH_CLOSED    = 13'b1000000000000
    } t_phase;

    // Result runs the front hands to the back.
    typedef enum logic [2:0] {
        OP_SILENT     = 3'd0,
        OP_GREET_OK   = 3'd1,
        OP_GREET_FAIL = 3'd2,
        OP_ERR        = 3'd3,
        OP_DOMAIN     = 3'd4,
        OP_DONE       = 3'd5,
        OP_RELAY      = 3'd6
    } t_op;

    localparam logic [IDX_W-1:0] ERR_REPLY_LEN = 4'd10;
    localparam logic [IDX_W-1:0] GREET_LEN     = 4'd2;
    localparam logic [IDX_W-1:0] SINGLE_LEN    = 4'd1;

    typedef struct packed {
        t_op                op;
        logic [BYTE_W-1:0]  data;
        logic [IPV4_W-1:0]  ipv4;
        logic [PORT_W-1:0]  port;
        logic               dom;
    } t_cmd;

    // Handshake between the queue head and the back.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

/* rtl/s5p_if.sv */
// Stream interfaces of the SOCKS5 request parser: input bytes and results.
interface s5p_in_if import s5p_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              new_conn;

    modport source (output valid, output in_byte, output new_conn, input ready);
    modport sink   (input valid, input in_byte, input new_conn, output ready);
endinterface

interface s5p_out_if import s5p_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] out_kind;
    logic [BYTE_W-1:0] out_byte;
    logic [IPV4_W-1:0] target_ipv4;
    logic [PORT_W-1:0] target_port;
    logic              target_is_domain;
    logic              last;
    logic              close_after;

    modport source (output valid, output out_kind, output out_byte, output target_ipv4,
                    output target_port, output target_is_domain, output last,
                    output close_after, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input target_ipv4,
                    input target_port, input target_is_domain, input last,
                    input close_after, output ready);
endinterface

/* rtl/socks5_request_parser_unit.sv */
// Top level of the SOCKS5 request parser: front, command queue and back.
// Throughput: one received byte per cycle while the four-entry command queue has room.
// With the queue empty, a byte's first result goes through a queue entry and then the back's output register.
// A bad request header gives a run of ten reply bytes; a greeting reply gives two.
// The back's output register sets the output rate of one result per cycle while the receiver is ready.
// Reset: i_rst_n is synchronous and active low; it empties the queue and the output.
module socks5_request_parser_unit import s5p_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    s5p_in_if.sink    i_in,
    s5p_out_if.source o_out
);

    // The front parses a byte in the cycle it is accepted and, when the byte
    // causes any results, writes one command into the queue. Bytes are taken
    // whenever the queue has a free entry, so a waiting result never blocks
    // input until the queue has filled behind it.
    logic  accept;
    logic  push;
    logic  pop;
    logic  full;
    t_cmd  cmd;
    t_head head;

    assign i_in.ready = !full;
    assign accept     = i_in.valid && !full;

    s5p_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_in.in_byte),
        .i_new_conn (i_in.new_conn),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    // The queue decouples parsing from the multi-cycle reply runs.
    s5p_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full)
    );

    // The back walks the head command one result per cycle while the output is not
    // stalled, and pops it with the last result of its run.
    s5p_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

/* rtl/s5p_front.sv */
// Front: walks the handshake one byte at a time and queues at most one result run per byte.
module s5p_front import s5p_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_new_conn,
    output logic              o_push,
    output t_cmd              o_cmd
);

    t_phase            r_phase,   n_phase,   e_phase;
    logic [BYTE_W-1:0] r_count,   n_count,   e_count;
    logic              r_no_auth, n_no_auth, e_no_auth;
    t_hdr_err          r_herr,    n_herr,    e_herr;
    logic [IPV4_W-1:0] r_ipv4,    n_ipv4,    e_ipv4;
    logic [PORT_W-1:0] r_port,    n_port,    e_port;
    logic              r_dom,     n_dom,     e_dom;
    logic [BYTE_W-1:0] cnt_dec;
    logic              push;
    t_cmd              cmd;

    // A new connection restarts every piece of state before the byte is parsed.
    always_comb begin
        if (i_new_conn) begin
            e_phase   = PH_GREET_VER;
            e_count   = '0;
            e_no_auth = 1'b0;
            e_herr    = HE_NONE;
            e_ipv4    = '0;
            e_port    = '0;
            e_dom     = 1'b0;
        end else begin
            e_phase   = r_phase;
            e_count   = r_count;
            e_no_auth = r_no_auth;
            e_herr    = r_herr;
            e_ipv4    = r_ipv4;
            e_port    = r_port;
            e_dom     = r_dom;
        end
    end

    assign cnt_dec = e_count - 8'd1;

    always_comb begin
        n_phase   = e_phase;
        n_count   = e_count;
        n_no_auth = e_no_auth;
        n_herr    = e_herr;
        n_ipv4    = e_ipv4;
        n_port    = e_port;
        n_dom     = e_dom;
        push      = 1'b0;
        cmd       = '{op: OP_SILENT, data: ZERO_BYTE, ipv4: '0, port: '0, dom: 1'b0};
        case (e_phase)
            PH_GREET_VER: begin
                n_herr  = (i_byte != SOCKS_VER) ? HE_BAD_HDR : HE_NONE;
                n_phase = PH_GREET_N;
            end
            PH_GREET_N: begin
                if (e_herr != HE_NONE) begin
                    push    = 1'b1;
                    cmd.op  = OP_SILENT;
                    n_phase = PH_CLOSED;
                end else if (i_byte == ZERO_BYTE) begin
                    push    = 1'b1;
                    cmd.op  = OP_GREET_FAIL;
                    n_phase = PH_CLOSED;
                end else begin
                    n_count   = i_byte;
                    n_no_auth = 1'b0;
                    n_phase   = PH_METHODS;
                end
            end
            PH_METHODS: begin
                n_no_auth = e_no_auth | (i_byte == METHOD_NOAUTH);
                n_count   = cnt_dec;
                if (cnt_dec == '0) begin
                    push = 1'b1;
                    if (n_no_auth) begin
                        cmd.op  = OP_GREET_OK;
                        n_phase = PH_REQ_VER;
                    end else begin
                        cmd.op  = OP_GREET_FAIL;
                        n_phase = PH_CLOSED;
                    end
                end
            end
            PH_REQ_VER: begin
                n_herr  = (i_byte != SOCKS_VER) ? HE_BAD_HDR : HE_NONE;
                n_phase = PH_REQ_CMD;
            end
            PH_REQ_CMD: begin
                if (e_herr == HE_NONE && i_byte != CMD_CONNECT) begin
                    n_herr = HE_BAD_CMD;
                end
                n_phase = PH_REQ_RSV;
            end
            PH_REQ_RSV: begin
                if (i_byte != RSV_BYTE) begin
                    n_herr = HE_BAD_HDR;
                end
                n_phase = PH_REQ_ATYP;
            end
            PH_REQ_ATYP: begin
                if (e_herr == HE_BAD_HDR) begin
                    push     = 1'b1;
                    cmd.op   = OP_ERR;
                    cmd.data = REP_GENERAL;
                    n_phase  = PH_CLOSED;
                end else if (e_herr != HE_NONE) begin
                    push     = 1'b1;
                    cmd.op   = OP_ERR;
                    cmd.data = REP_BAD_CMD;
                    n_phase  = PH_CLOSED;
                end else if (i_byte == ATYP_IPV4) begin
                    n_dom   = 1'b0;
                    n_ipv4  = '0;
                    n_count = IPV4_LEN;
                    n_phase = PH_IPV4;
                end else if (i_byte == ATYP_DOMAIN) begin
                    n_dom   = 1'b1;
                    n_ipv4  = '0;
                    n_phase = PH_DOMLEN;
                end else begin
                    push     = 1'b1;
                    cmd.op   = OP_ERR;
                    cmd.data = REP_BAD_ATYP;
                    n_phase  = PH_CLOSED;
                end
            end
            PH_IPV4: begin
                n_ipv4  = {e_ipv4[IPV4_W-BYTE_W-1:0], i_byte};
                n_count = cnt_dec;
                if (cnt_dec == '0) begin
                    n_count = PORT_LEN;
                    n_port  = '0;
                    n_phase = PH_PORT;
                end
            end
            PH_DOMLEN: begin
                n_port = '0;
                if (i_byte == ZERO_BYTE) begin
                    n_count = PORT_LEN;
                    n_phase = PH_PORT;
                end else begin
                    n_count = i_byte;
                    n_phase = PH_DOMAIN;
                end
            end
            PH_DOMAIN: begin
                push     = 1'b1;
                cmd.op   = OP_DOMAIN;
                cmd.data = i_byte;
                n_count  = cnt_dec;
                if (cnt_dec == '0) begin
                    n_count = PORT_LEN;
                    n_phase = PH_PORT;
                end
            end
            PH_PORT: begin
                n_port  = {e_port[PORT_W-BYTE_W-1:0], i_byte};
                n_count = cnt_dec;
                if (cnt_dec == '0) begin
                    push     = 1'b1;
                    cmd.op   = OP_DONE;
                    cmd.ipv4 = e_dom ? '0 : e_ipv4;
                    cmd.port = n_port;
                    cmd.dom  = e_dom;
                    n_phase  = PH_RELAY;
                end
            end
            PH_RELAY: begin
                push     = 1'b1;
                cmd.op   = OP_RELAY;
                cmd.data = i_byte;
            end
            default: begin
                n_phase = PH_CLOSED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_GREET_VER;
            r_count   <= '0;
            r_no_auth <= 1'b0;
            r_herr    <= HE_NONE;
            r_ipv4    <= '0;
            r_port    <= '0;
            r_dom     <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_no_auth <= n_no_auth;
            r_herr    <= n_herr;
            r_ipv4    <= n_ipv4;
            r_port    <= n_port;
            r_dom     <= n_dom;
        end
    end

    assign o_push = i_accept & push;
    assign o_cmd  = cmd;

endmodule

/* rtl/s5p_queue.sv */
// Short command queue between the parsing front and the result back.
module s5p_queue import s5p_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    input  logic  i_pop,
    output t_head o_head,
    output logic  o_full
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count,  n_count;

    // The depth is a power of two, so the pointers wrap by themselves.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];
    assign o_full       = (r_count == Q_CNT_W'(Q_DEPTH));

endmodule

/* rtl/s5p_back.sv */
// Back: expands each queued command into its run of results into the output register.
module s5p_back import s5p_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_head       i_head,
    output logic        o_pop,
    s5p_out_if.source   o_out
);

    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  run_len;
    logic              run_last;
    logic              run_close;
    logic [KIND_W-1:0] res_kind;
    logic [BYTE_W-1:0] res_byte;
    logic              advance;
    logic              r_valid;
    logic [KIND_W-1:0] r_kind;
    logic [BYTE_W-1:0] r_byte;
    logic [IPV4_W-1:0] r_ipv4;
    logic [PORT_W-1:0] r_port;
    logic              r_dom;
    logic              r_last;
    logic              r_close;

    always_comb begin
        run_len   = SINGLE_LEN;
        run_close = 1'b0;
        res_kind  = KIND_REPLY;
        res_byte  = ZERO_BYTE;
        case (i_head.cmd.op)
            OP_SILENT: begin
                run_close = 1'b1;
                res_kind  = KIND_SILENT;
            end
            OP_GREET_OK: begin
                run_len  = GREET_LEN;
                res_byte = (r_idx == '0) ? SOCKS_VER : METHOD_NOAUTH;
            end
            OP_GREET_FAIL: begin
                run_len   = GREET_LEN;
                run_close = 1'b1;
                res_byte  = (r_idx == '0) ? SOCKS_VER : METHOD_REJECT;
            end
            OP_ERR: begin
                // Version, reply code, reserved, IPv4 address type, then a zero
                // address and port.
                run_len   = ERR_REPLY_LEN;
                run_close = 1'b1;
                if (r_idx == 4'd0) begin
                    res_byte = SOCKS_VER;
                end else if (r_idx == 4'd1) begin
                    res_byte = i_head.cmd.data;
                end else if (r_idx == 4'd3) begin
                    res_byte = ATYP_IPV4;
                end else begin
                    res_byte = ZERO_BYTE;
                end
            end
            OP_DOMAIN: begin
                res_kind = KIND_DOMAIN;
                res_byte = i_head.cmd.data;
            end
            OP_DONE: begin
                res_kind = KIND_DONE;
            end
            OP_RELAY: begin
                res_kind = KIND_RELAY;
                res_byte = i_head.cmd.data;
            end
            default: begin
                res_kind = KIND_SILENT;
            end
        endcase
    end

    assign run_last = (r_idx == run_len - 1'b1);
    assign advance  = i_head.valid && (!r_valid || o_out.ready);
    assign o_pop    = advance && run_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_idx   <= run_last ? '0 : r_idx + 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind  <= res_kind;
            r_byte  <= res_byte;
            r_ipv4  <= i_head.cmd.ipv4;
            r_port  <= i_head.cmd.port;
            r_dom   <= i_head.cmd.dom;
            r_last  <= run_last;
            r_close <= run_close;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.out_kind         = r_kind;
    assign o_out.out_byte         = r_byte;
    assign o_out.target_ipv4      = r_ipv4;
    assign o_out.target_port      = r_port;
    assign o_out.target_is_domain = r_dom;
    assign o_out.last             = r_last;
    assign o_out.close_after      = r_close;

endmodule

/* rtl/s5p_checker.sv */
// Port-level checks on the result stream of the SOCKS5 request parser.
module s5p_checker import s5p_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input logic [KIND_W-1:0] i_kind,
    input logic [BYTE_W-1:0] i_byte,
    input logic [IPV4_W-1:0] i_ipv4,
    input logic [PORT_W-1:0] i_port,
    input logic              i_dom,
    input logic              i_last
);

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result withdrawn before it was taken");

    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_kind) && $stable(i_byte) && $stable(i_last))
        else $error("result changed while stalled");

    a_target_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != KIND_DONE |-> i_ipv4 == '0 && i_port == '0 && !i_dom)
        else $error("target fields set on a result that is not request complete");

    a_domain_no_ipv4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == KIND_DONE && i_dom |-> i_ipv4 == '0)
        else $error("IPv4 address given with a domain target");

    a_single_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_DOMAIN || i_kind == KIND_RELAY || i_kind == KIND_DONE
                    || i_kind == KIND_SILENT) |-> i_last)
        else $error("single result of a byte not marked last");

endmodule

bind socks5_request_parser_unit s5p_checker u_s5p_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_kind  (o_out.out_kind),
    .i_byte  (o_out.out_byte),
    .i_ipv4  (o_out.target_ipv4),
    .i_port  (o_out.target_port),
    .i_dom   (o_out.target_is_domain),
    .i_last  (o_out.last)
);

/* tb/s5p_result_checker.sv */
// Watches the byte and result channels, predicts the parser output and compares it.
`timescale 1ns / 1ps

module s5p_result_checker import s5p_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    s5p_in_if    i_byte_ch,
    s5p_out_if   i_res_ch,
    output int   o_mismatches,
    output int   o_pending
);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [IPV4_W-1:0] ipv4;
        logic [PORT_W-1:0] port;
        logic              dom;
        logic              last;
        logic              close_after;
    } t_parse_result;

    // Predicted parser state.
    t_phase            phase;
    logic [BYTE_W-1:0] remaining;
    logic              method_ok;
    t_hdr_err          hdr_err;
    logic [IPV4_W-1:0] ipv4_sr;
    logic [PORT_W-1:0] port_sr;
    logic              by_name;

    t_parse_result run_q[$];
    t_parse_result pending_results[$];
    int            mismatch_count = 0;

    task automatic clear_parser();
        phase     = PH_GREET_VER;
        remaining = '0;
        method_ok = 1'b0;
        hdr_err   = HE_NONE;
        ipv4_sr   = '0;
        port_sr   = '0;
        by_name   = 1'b0;
    endtask

    task automatic add_result(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                              input logic [IPV4_W-1:0] ipv4, input logic [PORT_W-1:0] port,
                              input logic dom);
        run_q.push_back('{kind, data, ipv4, port, dom, 1'b0, 1'b0});
    endtask

    // Advances the predicted parser by one received byte and queues its results.
    task automatic parse_byte(input logic [BYTE_W-1:0] rx, input logic nc);
        logic              closing;
        logic [BYTE_W-1:0] reply_code;
        closing    = 1'b0;
        reply_code = ZERO_BYTE;
        run_q.delete();
        if (nc) clear_parser();
        case (phase)
            PH_GREET_VER: begin
                hdr_err = (rx != SOCKS_VER) ? HE_BAD_HDR : HE_NONE;
                phase   = PH_GREET_N;
            end
            PH_GREET_N: begin
                if (hdr_err != HE_NONE) begin
                    add_result(KIND_SILENT, ZERO_BYTE, '0, '0, 1'b0);
                    closing = 1'b1;
                end else if (rx == ZERO_BYTE) begin
                    add_result(KIND_REPLY, SOCKS_VER, '0, '0, 1'b0);
                    add_result(KIND_REPLY, METHOD_REJECT, '0, '0, 1'b0);
                    closing = 1'b1;
                end else begin
                    remaining = rx;
                    method_ok = 1'b0;
                    phase     = PH_METHODS;
                end
            end
            PH_METHODS: begin
                if (rx == METHOD_NOAUTH) method_ok = 1'b1;
                remaining = remaining - 1'b1;
                if (remaining == '0) begin
                    add_result(KIND_REPLY, SOCKS_VER, '0, '0, 1'b0);
                    if (method_ok) begin
                        add_result(KIND_REPLY, METHOD_NOAUTH, '0, '0, 1'b0);
                        phase = PH_REQ_VER;
                    end else begin
                        add_result(KIND_REPLY, METHOD_REJECT, '0, '0, 1'b0);
                        closing = 1'b1;
                    end
                end
            end
            PH_REQ_VER: begin
                hdr_err = (rx != SOCKS_VER) ? HE_BAD_HDR : HE_NONE;
                phase   = PH_REQ_CMD;
            end
            PH_REQ_CMD: begin
                if (hdr_err == HE_NONE && rx != CMD_CONNECT) hdr_err = HE_BAD_CMD;
                phase = PH_REQ_RSV;
            end
            PH_REQ_RSV: begin
                if (rx != RSV_BYTE) hdr_err = HE_BAD_HDR;
                phase = PH_REQ_ATYP;
            end
            PH_REQ_ATYP: begin
                // A bad version or reserved byte outranks a bad command, and both
                // outrank an unknown address type.
                if (hdr_err == HE_BAD_HDR) begin
                    reply_code = REP_GENERAL;
                end else if (hdr_err != HE_NONE) begin
                    reply_code = REP_BAD_CMD;
                end else if (rx == ATYP_IPV4) begin
                    by_name   = 1'b0;
                    ipv4_sr   = '0;
                    remaining = IPV4_LEN;
                    phase     = PH_IPV4;
                end else if (rx == ATYP_DOMAIN) begin
                    by_name = 1'b1;
                    ipv4_sr = '0;
                    phase   = PH_DOMLEN;
                end else begin
                    reply_code = REP_BAD_ATYP;
                end
            end
            PH_IPV4: begin
                ipv4_sr   = {ipv4_sr[IPV4_W-BYTE_W-1:0], rx};
                remaining = remaining - 1'b1;
                if (remaining == '0) begin
                    remaining = PORT_LEN;
                    port_sr   = '0;
                    phase     = PH_PORT;
                end
            end
            PH_DOMLEN: begin
                port_sr = '0;
                if (rx == ZERO_BYTE) begin
                    remaining = PORT_LEN;
                    phase     = PH_PORT;
                end else begin
                    remaining = rx;
                    phase     = PH_DOMAIN;
                end
            end
            PH_DOMAIN: begin
                add_result(KIND_DOMAIN, rx, '0, '0, 1'b0);
                remaining = remaining - 1'b1;
                if (remaining == '0) begin
                    remaining = PORT_LEN;
                    phase     = PH_PORT;
                end
            end
            PH_PORT: begin
                port_sr   = {port_sr[PORT_W-BYTE_W-1:0], rx};
                remaining = remaining - 1'b1;
                if (remaining == '0) begin
                    add_result(KIND_DONE, ZERO_BYTE, by_name ? '0 : ipv4_sr, port_sr, by_name);
                    phase = PH_RELAY;
                end
            end
            PH_RELAY: begin
                add_result(KIND_RELAY, rx, '0, '0, 1'b0);
            end
            default: begin
                phase = PH_CLOSED;
            end
        endcase
        if (reply_code != ZERO_BYTE) begin
            add_result(KIND_REPLY, SOCKS_VER, '0, '0, 1'b0);
            add_result(KIND_REPLY, reply_code, '0, '0, 1'b0);
            add_result(KIND_REPLY, ZERO_BYTE, '0, '0, 1'b0);
            add_result(KIND_REPLY, ATYP_IPV4, '0, '0, 1'b0);
            repeat (6) add_result(KIND_REPLY, ZERO_BYTE, '0, '0, 1'b0);
            closing = 1'b1;
        end
        if (closing) phase = PH_CLOSED;
        foreach (run_q[i]) begin
            run_q[i].last        = (i == run_q.size() - 1);
            run_q[i].close_after = closing;
            pending_results.push_back(run_q[i]);
        end
    endtask

    function automatic string show(input t_parse_result r);
        return $sformatf("kind %0d byte %02h ipv4 %08h port %04h dom %0d last %0d close %0d",
                         r.kind, r.data, r.ipv4, r.port, r.dom, r.last, r.close_after);
    endfunction

    task automatic flag_mismatch(input string why, input t_parse_result want,
                                 input t_parse_result seen);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t ns: %s", $time, why);
            $display("    expected %s", show(want));
            $display("    actual   %s", show(seen));
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_parse_result seen;
        t_parse_result want;
        if (!i_rst_n) begin
            clear_parser();
            pending_results.delete();
        end else begin
            if (i_byte_ch.valid && i_byte_ch.ready) begin
                parse_byte(i_byte_ch.in_byte, i_byte_ch.new_conn);
            end
            if (i_res_ch.valid && i_res_ch.ready) begin
                seen = {i_res_ch.out_kind, i_res_ch.out_byte, i_res_ch.target_ipv4,
                        i_res_ch.target_port, i_res_ch.target_is_domain, i_res_ch.last,
                        i_res_ch.close_after};
                if (pending_results.size() == 0) begin
                    flag_mismatch("result with none expected", '0, seen);
                end else begin
                    want = pending_results.pop_front();
                    if (seen !== want) flag_mismatch("result differs", want, seen);
                end
            end
        end
        o_pending    <= pending_results.size();
        o_mismatches <= mismatch_count;
    end

endmodule

/* tb/tb_socks5_request_parser_unit.sv */
// Testbench top: drives SOCKS5 handshakes into the parser and gives the verdict.
`timescale 1ns / 1ps

module tb_socks5_request_parser_unit;
    import s5p_pkg::*;

    // Random items to send after the directed part; trailing bytes sent without a restart are not counted.
    localparam int RANDOM_ITEMS = 234;
    // The receiver refuses results for this many cycles once this many items have gone in.
    localparam int HOLD_AT      = 180;
    localparam int HOLD_CYCLES  = 120;
    // While this range of items is being sent, neither side idles.
    localparam int CALM_FROM    = 60;
    localparam int CALM_TO      = 120;
    localparam int DRAIN_CYCLES = 30;
    localparam int LIMIT_CYCLES = 100000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   sent = 0;
    int   cycles = 0;

    // Each stimulus entry holds {new_conn, byte}.
    logic [BYTE_W:0] stim_q[$];

    s5p_in_if  byte_ch ();
    s5p_out_if res_ch ();

    socks5_request_parser_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (res_ch)
    );

    s5p_result_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_byte_ch    (byte_ch),
        .i_res_ch     (res_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic bit calm_window();
        return sent >= CALM_FROM && sent < CALM_TO;
    endfunction

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic nc);
        stim_q.push_back({nc, b});
    endtask

    // Receiver: mostly ready, idles about one cycle in six, except in the calm window.
    // Once, part-way through the run, it refuses results for a long stretch so that
    // the command queue fills up and the parser has to hold off the byte stream.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (!hold_done && sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= calm_window() || ($urandom_range(0, 99) >= 16);
            end
        end
    end

    // A generous ceiling on the run; a hang anywhere ends here.
    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [BYTE_W-1:0] sess[$];
        logic [BYTE_W-1:0] ver;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] rsv;
        logic [BYTE_W-1:0] atyp;
        int                random_items;
        int                n_meth;
        int                noauth_at;
        int                dom_len;
        int                cut;
        int                total;
        bit                offers_noauth;

        rst_n            <= 1'b0;
        byte_ch.valid    <= 1'b0;
        byte_ch.in_byte  <= '0;
        byte_ch.new_conn <= 1'b0;

        // Directed part. A greeting with a bad version is closed silently once the
        // method count arrives, and a later byte without a restart is ignored.
        push_byte(8'hFF, 1'b1); push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
        // A greeting that offers no methods at all is rejected.
        push_byte(SOCKS_VER, 1'b1); push_byte(ZERO_BYTE, 1'b0);
        // A full IPv4 request with an all-ones address and port, then relay extremes.
        push_byte(SOCKS_VER, 1'b1); push_byte(8'h01, 1'b0); push_byte(METHOD_NOAUTH, 1'b0);
        push_byte(SOCKS_VER, 1'b0); push_byte(CMD_CONNECT, 1'b0);
        push_byte(RSV_BYTE, 1'b0); push_byte(ATYP_IPV4, 1'b0);
        repeat (6) push_byte(8'hFF, 1'b0);
        push_byte(ZERO_BYTE, 1'b0); push_byte(8'hFF, 1'b0);
        // Bad command together with a bad reserved byte: the general error code wins.
        push_byte(SOCKS_VER, 1'b1); push_byte(8'h01, 1'b0); push_byte(METHOD_NOAUTH, 1'b0);
        push_byte(SOCKS_VER, 1'b0); push_byte(8'h02, 1'b0);
        push_byte(8'h01, 1'b0); push_byte(ATYP_IPV4, 1'b0);

        // Random part: mostly well-formed handshakes with random content, so that the
        // parser gets through to the address, port and relay phases, mixed with bad
        // versions, rejected methods, header errors and sessions cut short by a restart.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            sess.delete();
            if ($urandom_range(0, 99) < 8) begin
                // Bad greeting version; the method count that follows closes the session silently.
                ver = BYTE_W'($urandom_range(0, 255));
                if (ver == SOCKS_VER) ver = ~SOCKS_VER;
                sess.push_back(ver);
                sess.push_back(BYTE_W'($urandom_range(0, 255)));
            end else begin
                sess.push_back(SOCKS_VER);
                if ($urandom_range(0, 99) < 8) begin
                    n_meth = 0;
                end else if ($urandom_range(0, 9) == 0) begin
                    n_meth = $urandom_range(7, 40);
                end else begin
                    n_meth = $urandom_range(1, 6);
                end
                sess.push_back(BYTE_W'(n_meth));
                offers_noauth = ($urandom_range(0, 99) < 80);
                noauth_at     = $urandom_range(0, (n_meth > 0) ? n_meth - 1 : 0);
                for (int i = 0; i < n_meth; i++) begin
                    if (offers_noauth && i == noauth_at) begin
                        sess.push_back(METHOD_NOAUTH);
                    end else if (offers_noauth) begin
                        sess.push_back(BYTE_W'($urandom_range(0, 255)));
                    end else begin
                        sess.push_back(BYTE_W'($urandom_range(1, 255)));
                    end
                end
                if (n_meth > 0 && offers_noauth) begin
                    ver  = ($urandom_range(0, 99) < 90) ? SOCKS_VER :
                           BYTE_W'($urandom_range(0, 255));
                    cmd  = ($urandom_range(0, 99) < 85) ? CMD_CONNECT :
                           BYTE_W'($urandom_range(0, 255));
                    rsv  = ($urandom_range(0, 99) < 90) ? RSV_BYTE :
                           BYTE_W'($urandom_range(0, 255));
                    cut  = $urandom_range(0, 99);
                    atyp = (cut < 45) ? ATYP_IPV4 :
                           (cut < 90) ? ATYP_DOMAIN : BYTE_W'($urandom_range(0, 255));
                    sess.push_back(ver);
                    sess.push_back(cmd);
                    sess.push_back(rsv);
                    sess.push_back(atyp);
                    if (ver == SOCKS_VER && cmd == CMD_CONNECT && rsv == RSV_BYTE &&
                        (atyp == ATYP_IPV4 || atyp == ATYP_DOMAIN)) begin
                        if (atyp == ATYP_IPV4) begin
                            repeat (4) sess.push_back(BYTE_W'($urandom_range(0, 255)));
                        end else begin
                            if ($urandom_range(0, 99) < 12) begin
                                dom_len = 0;
                            end else if ($urandom_range(0, 9) == 0) begin
                                dom_len = $urandom_range(17, 40);
                            end else begin
                                dom_len = $urandom_range(1, 16);
                            end
                            sess.push_back(BYTE_W'(dom_len));
                            repeat (dom_len) sess.push_back(BYTE_W'($urandom_range(0, 255)));
                        end
                        repeat (2) sess.push_back(BYTE_W'($urandom_range(0, 255)));
                        repeat ($urandom_range(0, 8)) begin
                            sess.push_back(BYTE_W'($urandom_range(0, 255)));
                        end
                    end
                end
            end
            // Now and then a session is broken off part-way by the next restart.
            if ($urandom_range(0, 99) < 10) begin
                cut = $urandom_range(1, sess.size());
                while (sess.size() > cut) void'(sess.pop_back());
            end
            foreach (sess[i]) push_byte(sess[i], i == 0);
            random_items += sess.size();
            // Trailing bytes without a restart: relay data or ignored after a close.
            if ($urandom_range(0, 99) < 20) begin
                repeat ($urandom_range(1, 3)) begin
                    push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
                end
            end
        end
        total = stim_q.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Sender: an offered item stays put until it is taken; between items the
        // sender idles about one cycle in six, except in the calm window.
        while (sent < total) begin
            @(posedge clk);
            if (byte_ch.valid && byte_ch.ready) sent++;
            if (!(byte_ch.valid && !byte_ch.ready)) begin
                if (sent < total && (calm_window() || $urandom_range(0, 99) >= 16)) begin
                    byte_ch.valid    <= 1'b1;
                    byte_ch.in_byte  <= stim_q[sent][BYTE_W-1:0];
                    byte_ch.new_conn <= stim_q[sent][BYTE_W];
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end

        // The checker's count of outstanding results is registered and settles after the
        // last item; then let every expected result arrive and give strays time.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/s5p_pkg.sv
rtl/s5p_if.sv
rtl/s5p_front.sv
rtl/s5p_queue.sv
rtl/s5p_back.sv
rtl/socks5_request_parser_unit.sv
rtl/s5p_checker.sv
tb/s5p_result_checker.sv
tb/tb_socks5_request_parser_unit.sv
